FILE: hw/rtl/b2a_pkg.sv
// ----------------------------------------------------------------------------
// b2a_pkg
// Shared types and constants of the binary to ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2a_pkg;

    localparam int unsigned NUM_WIDTH   = 32;
    localparam int unsigned NUM_DIGITS  = 10;
    localparam int unsigned DIGIT_WIDTH = 4;
    localparam int unsigned BCD_WIDTH   = NUM_DIGITS * DIGIT_WIDTH;
    localparam int unsigned CNT_WIDTH   = 5;

    localparam logic [7:0] ASCII_ZERO        = 8'h30;
    localparam logic [7:0] HEX_LETTER_OFFSET = 8'h37;
    localparam logic [7:0] ASCII_NUL         = 8'h00;

    localparam logic OPCODE_DEC = 1'b0;
    localparam logic OPCODE_HEX = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_EMIT = 4'b0100,
        S_TERM = 4'b1000
    } t_state;

    typedef struct packed {
        logic load_dec;
        logic load_hex;
        logic step;
        logic shift_out;
    } t_dig_ctrl;

    function automatic logic [7:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
        logic [7:0] d8;
        d8 = {4'h0, d};
        if (d > 4'd9) begin
            return d8 + HEX_LETTER_OFFSET;
        end
        return d8 + ASCII_ZERO;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b2a_if.sv
// ----------------------------------------------------------------------------
// b2a channel interfaces
// Valid/ready channels for the number input and the character output.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2a_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] number_in;
    logic        opcode;

    modport source (output valid, output number_in, output opcode, input ready);
    modport sink   (input valid, input number_in, input opcode, output ready);
endinterface

interface b2a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/b2a_digit_reg.sv
// ----------------------------------------------------------------------------
// b2a_digit_reg
// Digit register: bit-serial double dabble for decimal, direct nibble load
// for hex, and a nibble-wide shift toward the top digit for output.
// ----------------------------------------------------------------------------
`default_nettype none

module b2a_digit_reg (
    input  wire logic                                i_clk,
    input  wire b2a_pkg::t_dig_ctrl                  i_ctrl,
    input  wire logic [b2a_pkg::NUM_WIDTH-1:0]       i_number,
    output logic      [b2a_pkg::DIGIT_WIDTH-1:0]     o_top_digit
);

    logic [b2a_pkg::NUM_WIDTH-1:0] r_bin;
    logic [b2a_pkg::NUM_WIDTH-1:0] n_bin;
    logic [b2a_pkg::BCD_WIDTH-1:0] r_bcd;
    logic [b2a_pkg::BCD_WIDTH-1:0] n_bcd;
    logic [b2a_pkg::BCD_WIDTH-1:0] w_adj;

    always_comb begin
        for (int i = 0; i < b2a_pkg::NUM_DIGITS; i++) begin
            if (r_bcd[i*b2a_pkg::DIGIT_WIDTH +: b2a_pkg::DIGIT_WIDTH] >= 4'd5) begin
                w_adj[i*b2a_pkg::DIGIT_WIDTH +: b2a_pkg::DIGIT_WIDTH] =
                    r_bcd[i*b2a_pkg::DIGIT_WIDTH +: b2a_pkg::DIGIT_WIDTH] + 4'd3;
            end else begin
                w_adj[i*b2a_pkg::DIGIT_WIDTH +: b2a_pkg::DIGIT_WIDTH] =
                    r_bcd[i*b2a_pkg::DIGIT_WIDTH +: b2a_pkg::DIGIT_WIDTH];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_ctrl.load_dec) begin
            n_bin = i_number;
            n_bcd = '0;
        end else if (i_ctrl.load_hex) begin
            n_bcd = {{(b2a_pkg::BCD_WIDTH - b2a_pkg::NUM_WIDTH){1'b0}}, i_number};
        end else if (i_ctrl.step) begin
            n_bcd = {w_adj[b2a_pkg::BCD_WIDTH-2:0], r_bin[b2a_pkg::NUM_WIDTH-1]};
            n_bin = {r_bin[b2a_pkg::NUM_WIDTH-2:0], 1'b0};
        end else if (i_ctrl.shift_out) begin
            n_bcd = {r_bcd[b2a_pkg::BCD_WIDTH-b2a_pkg::DIGIT_WIDTH-1:0],
                     {b2a_pkg::DIGIT_WIDTH{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[b2a_pkg::BCD_WIDTH-1 -: b2a_pkg::DIGIT_WIDTH];

endmodule

`default_nettype wire

FILE: hw/rtl/binary_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_formatter
// Formats a 32-bit unsigned number as decimal or upper-case hex ASCII text,
// most significant digit first, without leading zeros, closed by a NUL.
// ----------------------------------------------------------------------------
//  channel  dir  payload                 transaction
//  i_in     in   number_in[31:0], opcode  one number to format
//  o_out    out  text_char[7:0], last_char one character; last on the NUL
//
//  Decimal: bit-serial double dabble over all 32 input bits, then a 10-digit
//  scan at one digit per cycle, except where it stalls, plus the terminator.
//  Hex: the scan and terminator only.
//  The scan stalls while the output register is full and not taken.
//  A new transaction is taken once the terminator sits in the output register.
//  Synchronous active-low reset returns to idle with the output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_ascii_formatter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    b2a_in_if.sink     i_in,
    b2a_out_if.source  o_out
);

    b2a_pkg::t_state                      r_state;
    b2a_pkg::t_state                      n_state;
    logic [b2a_pkg::CNT_WIDTH-1:0]        r_cnt;
    logic [b2a_pkg::CNT_WIDTH-1:0]        n_cnt;
    logic                                 r_started;
    logic                                 n_started;
    logic                                 r_out_valid;
    logic                                 n_out_valid;
    logic [7:0]                           r_out_char;
    logic [7:0]                           n_out_char;
    logic                                 r_out_last;
    logic                                 n_out_last;

    b2a_pkg::t_dig_ctrl                   w_ctrl;
    logic [b2a_pkg::DIGIT_WIDTH-1:0]      w_top;
    logic                                 w_accept;
    logic                                 w_slot_free;
    logic                                 w_last_digit;
    logic                                 w_emit;
    logic                                 w_load;

    localparam logic [b2a_pkg::CNT_WIDTH-1:0] CONV_LAST =
        b2a_pkg::CNT_WIDTH'(b2a_pkg::NUM_WIDTH - 1);
    localparam logic [b2a_pkg::CNT_WIDTH-1:0] DIGIT_LAST =
        b2a_pkg::CNT_WIDTH'(b2a_pkg::NUM_DIGITS - 1);

    b2a_digit_reg u_digit_reg (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_number    (i_in.number_in),
        .o_top_digit (w_top)
    );

    assign i_in.ready   = (r_state == b2a_pkg::S_IDLE);
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_slot_free  = !r_out_valid || o_out.ready;
    assign w_last_digit = (r_cnt == DIGIT_LAST);
    assign w_emit       = r_started || (w_top != '0) || w_last_digit;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_started  = r_started;
        n_out_char = r_out_char;
        n_out_last = r_out_last;
        w_load     = 1'b0;
        w_ctrl     = '0;
        case (r_state)
            b2a_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cnt     = '0;
                    n_started = 1'b0;
                    if (i_in.opcode == b2a_pkg::OPCODE_HEX) begin
                        w_ctrl.load_hex = 1'b1;
                        n_state         = b2a_pkg::S_EMIT;
                    end else begin
                        w_ctrl.load_dec = 1'b1;
                        n_state         = b2a_pkg::S_CONV;
                    end
                end
            end
            b2a_pkg::S_CONV: begin
                w_ctrl.step = 1'b1;
                if (r_cnt == CONV_LAST) begin
                    n_cnt   = '0;
                    n_state = b2a_pkg::S_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            b2a_pkg::S_EMIT: begin
                if (!w_emit) begin
                    w_ctrl.shift_out = 1'b1;
                    n_cnt            = r_cnt + 1'b1;
                end else if (w_slot_free) begin
                    w_ctrl.shift_out = 1'b1;
                    w_load           = 1'b1;
                    n_out_char       = b2a_pkg::digit_to_ascii(w_top);
                    n_out_last       = 1'b0;
                    n_started        = 1'b1;
                    if (w_last_digit) begin
                        n_state = b2a_pkg::S_TERM;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            b2a_pkg::S_TERM: begin
                if (w_slot_free) begin
                    w_load     = 1'b1;
                    n_out_char = b2a_pkg::ASCII_NUL;
                    n_out_last = 1'b1;
                    n_state    = b2a_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = b2a_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= b2a_pkg::S_IDLE;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.text_char = r_out_char;
    assign o_out.last_char = r_out_last;

    a_dec_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.opcode == b2a_pkg::OPCODE_DEC)) |=> (r_state == b2a_pkg::S_CONV))
        else $error("decimal transaction did not enter conversion");

    a_term_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_out_last) |=> (r_state == b2a_pkg::S_IDLE))
        else $error("terminator issued without returning to idle");

    a_last_digit_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == b2a_pkg::S_EMIT) && w_last_digit) |-> w_emit)
        else $error("final digit was skipped");

    a_nul_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_char == b2a_pkg::ASCII_NUL) == r_out_last))
        else $error("NUL and last flag disagree");

endmodule

`default_nettype wire
